// ----- rtl/wdf_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared beat types, result kind codes and the default queue depth.
// ----------------------------------------------------------------------------
package wdf_pkg;

  // Result kind codes.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_TRUNC  = 2'd2;

  // Default depth of the queue between the parser and the result stage.
  localparam int unsigned QUEUE_DEPTH = 4;

  // One input beat: a raw byte of the received buffer.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } wdf_in_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        masked_flag;
    logic [63:0] payload_length;
    logic [3:0]  header_length;
    logic [7:0]  data_byte;
    logic        frame_end;
  } wdf_out_t;

  // Work handed from the parser to the result stage for one input byte:
  // an optional header or data result, then an optional truncation error.
  typedef struct packed {
    logic     has_result;
    logic     has_error;
    wdf_out_t result;
  } wdf_cmd_t;

endpackage

// ----- rtl/websocket_frame_deframer_top.sv -----
// A result beat is registered in the queue and then in the output register.
// Throughput: one byte per cycle while the queue has room; the result stage
// gives one beat per cycle while the output is not stalled, so a byte that
// yields two beats (result plus truncation) occupies it for both. The command
// queue of QueueDepth entries absorbs that and output stalls.
// Reset: rst_ni clears the parser to idle and empties queue and output register.
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses received frame bytes into header and unmasked payload beats.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top
  import wdf_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  wdf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output wdf_out_t out_data_o
);

  logic     push, full, pop, empty;
  wdf_cmd_t push_cmd, pop_cmd;

  // Front: header parsing and unmasking.
  wdf_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  // Queue between the two sides.
  wdf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_cmd_o  (pop_cmd)
  );

  // Back: result beats.
  wdf_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/wdf_parser.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer parser
// Walks the frame header byte by byte, unmasks payload bytes and hands the
// results of each byte to the queue as one command.
// ----------------------------------------------------------------------------
module wdf_parser
  import wdf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  wdf_in_t  in_data_i,
  output logic     push_o,
  output wdf_cmd_t push_cmd_o,
  input  logic     full_i
);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_e;

  // Header byte counts at which an extended length is complete.
  localparam logic [3:0] HDR_LEN_EXT16 = 4'd4;
  localparam logic [3:0] HDR_LEN_EXT64 = 4'd10;
  localparam logic [6:0] LEN_CODE_16   = 7'd126;
  localparam logic [6:0] LEN_CODE_64   = 7'd127;
  localparam logic [63:0] KEY_BYTES    = 64'd4;

  phase_e      phase_q, phase_d;
  logic [3:0]  hc_q, hc_d;
  logic        fin_q, fin_d;
  logic [3:0]  opc_q, opc_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic [63:0] pc_q, pc_d;

  logic       accept;
  logic       after_len;
  logic       hdr_done;
  logic [7:0] b;
  logic [7:0] key_byte;
  wdf_cmd_t   cmd;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;
  assign b          = in_data_i.in_byte;
  // Key byte at payload position modulo four, most significant first.
  assign key_byte   = key_q[{~pc_q[1:0], 3'b000} +: 8];

  // Next-state and result logic for one byte.
  always_comb begin
    phase_d   = phase_q;
    hc_d      = hc_q;
    fin_d     = fin_q;
    opc_d     = opc_q;
    mask_d    = mask_q;
    len_d     = len_q;
    key_d     = key_q;
    pc_d      = pc_q;
    after_len = 1'b0;
    hdr_done  = 1'b0;
    cmd       = '0;

    case (phase_q)
      PH_HDR1: begin
        mask_d = b[7];
        hc_d   = 4'd2;
        if (b[6:0] == LEN_CODE_16) begin
          len_d   = '0;
          phase_d = PH_EXT16;
        end else if (b[6:0] == LEN_CODE_64) begin
          len_d   = '0;
          phase_d = PH_EXT64;
        end else begin
          len_d     = {57'd0, b[6:0]};
          after_len = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_d = {len_q[55:0], b};
        hc_d  = hc_q + 4'd1;
        if (hc_d == ((phase_q == PH_EXT16) ? HDR_LEN_EXT16 : HDR_LEN_EXT64)) begin
          after_len = 1'b1;
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], b};
        hc_d  = hc_q + 4'd1;
        pc_d  = pc_q + 64'd1;
        if (pc_d >= KEY_BYTES) begin
          hdr_done = 1'b1;
        end
      end
      PH_DATA: begin
        pc_d                     = pc_q + 64'd1;
        cmd.has_result           = 1'b1;
        cmd.result.result_kind   = KIND_DATA;
        cmd.result.data_byte     = b ^ key_byte;
        cmd.result.frame_end     = (pc_d == len_q);
        if (pc_d == len_q) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        fin_d   = b[7];
        opc_d   = b[3:0];
        mask_d  = 1'b0;
        len_d   = '0;
        key_d   = '0;
        pc_d    = '0;
        hc_d    = 4'd1;
        phase_d = PH_HDR1;
      end
    endcase

    // Length known: a masked frame still needs its key.
    if (after_len) begin
      if (mask_d) begin
        phase_d = PH_KEY;
        pc_d    = '0;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // Header complete: a zero-length frame ends here.
    if (hdr_done) begin
      cmd.has_result         = 1'b1;
      cmd.result.result_kind = KIND_HEADER;
      cmd.result.frame_end   = (len_d == '0);
      pc_d                   = '0;
      phase_d                = (len_d == '0) ? PH_IDLE : PH_DATA;
    end

    // Fields common to header and data results come from the updated state.
    cmd.result.fin_flag       = fin_d;
    cmd.result.frame_opcode   = opc_d;
    cmd.result.masked_flag    = mask_d;
    cmd.result.payload_length = len_d;
    cmd.result.header_length  = hc_d;

    // Buffer ended inside a frame: report truncation and start over.
    if (in_data_i.end_of_buffer && (phase_d != PH_IDLE)) begin
      cmd.has_error = 1'b1;
      phase_d       = PH_IDLE;
      hc_d          = '0;
      fin_d         = 1'b0;
      opc_d         = '0;
      mask_d        = 1'b0;
      len_d         = '0;
      key_d         = '0;
      pc_d          = '0;
    end
  end

  assign push_o     = accept & (cmd.has_result | cmd.has_error);
  assign push_cmd_o = cmd;

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hc_q    <= '0;
      fin_q   <= 1'b0;
      opc_q   <= '0;
      mask_q  <= 1'b0;
      len_q   <= '0;
      key_q   <= '0;
      pc_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      fin_q   <= fin_d;
      opc_q   <= opc_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
      key_q   <= key_d;
      pc_q    <= pc_d;
    end
  end

endmodule

// ----- rtl/wdf_queue.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer command queue
// Small first-in first-out queue that lets parser and result stage stall apart.
// ----------------------------------------------------------------------------
module wdf_queue
  import wdf_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  wdf_cmd_t push_cmd_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output wdf_cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  wdf_cmd_t        entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o    = (count_q == FullCnt);
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & ~empty_o;
  assign pop_cmd_o = entries_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/wdf_emitter.sv -----
// ----------------------------------------------------------------------------
// WebSocket deframer result stage
// Turns each queued command into one or two result beats in an output register.
// ----------------------------------------------------------------------------
module wdf_emitter
  import wdf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  wdf_cmd_t cmd_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output wdf_out_t out_data_o
);

  logic     out_valid_q;
  wdf_out_t out_q;
  logic     err_pend_q;
  logic     load;
  wdf_out_t err_beat;

  // Truncation beat: all fields zero but kind and frame end.
  always_comb begin
    err_beat             = '0;
    err_beat.result_kind = KIND_TRUNC;
    err_beat.frame_end   = 1'b1;
  end

  assign load        = ~out_valid_q | out_ready_i;
  assign pop_o       = load & ~err_pend_q & ~empty_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Output register; a pending error goes out before the next command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      err_pend_q  <= 1'b0;
      out_q       <= '0;
    end else if (load) begin
      if (err_pend_q) begin
        out_valid_q <= 1'b1;
        out_q       <= err_beat;
        err_pend_q  <= 1'b0;
      end else if (!empty_i) begin
        out_valid_q <= 1'b1;
        if (cmd_i.has_result) begin
          out_q      <= cmd_i.result;
          err_pend_q <= cmd_i.has_error;
        end else begin
          out_q <= err_beat;
        end
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- sim/websocket_frame_deframer_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Feeds directed and random frame bytes, tracks the parse in a local model of
// the deframer and checks every result beat against the oldest expected beat.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top_tb;
  import wdf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_BEATS = 700;

  // Parse phases of the local deframer model.
  typedef enum logic [2:0] {
    PS_IDLE, PS_LEN, PS_EXT16, PS_EXT64, PS_KEY, PS_DATA
  } parse_state_e;

  // One directed stimulus row; pinned rows carry the last expected beat typed in.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       eob;
    logic       pinned;
    wdf_out_t   want;
  } dir_row_t;

  localparam wdf_out_t NO_BEAT   = '0;
  localparam wdf_out_t PING_HDR  = '{KIND_HEADER, 1'b1, 4'h9, 1'b0, 64'd0, 4'd2, 8'h00, 1'b1};
  localparam wdf_out_t TRUNC_ERR = '{KIND_TRUNC, 1'b0, 4'h0, 1'b0, 64'd0, 4'd0, 8'h00, 1'b1};

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  wdf_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  wdf_out_t out_data_o;

  // Model state.
  parse_state_e p_state = PS_IDLE;
  logic [3:0]   p_hdr_cnt = '0;
  logic         p_fin = 1'b0;
  logic [3:0]   p_opc = '0;
  logic         p_msk = 1'b0;
  logic [63:0]  p_len = '0;
  logic [31:0]  p_key = '0;
  logic [63:0]  p_cnt = '0;

  wdf_out_t frame_results_q [$];
  wdf_in_t  frame_bytes_q [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned random_sent = 0;
  logic        steady = 1'b0;

  dir_row_t dir_tab [25] = '{
    // Zero-length ping: the header beat ends the frame.
    '{8'h89, 1'b0, 1'b0, NO_BEAT}, '{8'h00, 1'b0, 1'b1, PING_HDR},
    // Buffer ends after the first header byte.
    '{8'h81, 1'b1, 1'b1, TRUNC_ERR},
    // Masked frame with one payload byte.
    '{8'h82, 1'b0, 1'b0, NO_BEAT}, '{8'h81, 1'b0, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, 1'b0, NO_BEAT}, '{8'h00, 1'b0, 1'b0, NO_BEAT},
    '{8'hA5, 1'b0, 1'b0, NO_BEAT}, '{8'h5A, 1'b0, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, 1'b0, NO_BEAT},
    // 16-bit length, frame finishes exactly on the end of the buffer.
    '{8'h01, 1'b0, 1'b0, NO_BEAT}, '{8'h7E, 1'b0, 1'b0, NO_BEAT},
    '{8'h00, 1'b0, 1'b0, NO_BEAT}, '{8'h01, 1'b0, 1'b0, NO_BEAT},
    '{8'hFF, 1'b1, 1'b0, NO_BEAT},
    // Largest 64-bit length, header completes on the last byte of the buffer.
    '{8'h8A, 1'b0, 1'b0, NO_BEAT}, '{8'h7F, 1'b0, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, 1'b0, NO_BEAT}, '{8'hFF, 1'b0, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, 1'b0, NO_BEAT}, '{8'hFF, 1'b0, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, 1'b0, NO_BEAT}, '{8'hFF, 1'b0, 1'b0, NO_BEAT},
    '{8'hFF, 1'b0, 1'b0, NO_BEAT}, '{8'hFF, 1'b1, 1'b1, TRUNC_ERR}
  };

  websocket_frame_deframer_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Clock, 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic string beat_str(wdf_out_t r);
    return $sformatf("kind=%0d fin=%0d op=%h mask=%0d len=%h hlen=%0d data=%h end=%0d",
                     r.result_kind, r.fin_flag, r.frame_opcode, r.masked_flag,
                     r.payload_length, r.header_length, r.data_byte, r.frame_end);
  endfunction

  // Appends a result beat built from the current frame fields.
  function automatic void push_result(logic [1:0] kind, logic [7:0] data, logic last);
    wdf_out_t r;
    r.result_kind    = kind;
    r.fin_flag       = p_fin;
    r.frame_opcode   = p_opc;
    r.masked_flag    = p_msk;
    r.payload_length = p_len;
    r.header_length  = p_hdr_cnt;
    r.data_byte      = data;
    r.frame_end      = last;
    frame_results_q.push_back(r);
  endfunction

  // Header finished: a zero-length frame ends here, otherwise payload follows.
  function automatic void close_header();
    if (p_len == 64'd0) begin
      push_result(KIND_HEADER, 8'h00, 1'b1);
      p_state = PS_IDLE;
    end else begin
      push_result(KIND_HEADER, 8'h00, 1'b0);
      p_state = PS_DATA;
      p_cnt   = '0;
    end
  endfunction

  // Length known: a masked frame still needs its four key bytes.
  function automatic void length_known();
    if (p_msk) begin
      p_state = PS_KEY;
      p_cnt   = '0;
    end else begin
      close_header();
    end
  endfunction

  // Advances the model by one accepted byte and queues the beats it causes.
  function automatic void parse_byte(wdf_in_t beat);
    logic [7:0] b;
    wdf_out_t   err;
    int         pos;
    b = beat.in_byte;
    case (p_state)
      PS_LEN: begin
        p_msk     = b[7];
        p_hdr_cnt = 4'd2;
        if (b[6:0] == 7'd126) begin
          p_len   = '0;
          p_state = PS_EXT16;
        end else if (b[6:0] == 7'd127) begin
          p_len   = '0;
          p_state = PS_EXT64;
        end else begin
          p_len = {57'd0, b[6:0]};
          length_known();
        end
      end
      PS_EXT16, PS_EXT64: begin
        p_len = {p_len[55:0], b};
        p_hdr_cnt++;
        if (p_hdr_cnt == ((p_state == PS_EXT16) ? 4'd4 : 4'd10)) length_known();
      end
      PS_KEY: begin
        p_key = {p_key[23:0], b};
        p_hdr_cnt++;
        p_cnt++;
        if (p_cnt >= 64'd4) close_header();
      end
      PS_DATA: begin
        // Key bytes are used most significant first.
        pos = 3 - int'(p_cnt[1:0]);
        b   = b ^ p_key[8*pos +: 8];
        p_cnt++;
        if (p_cnt == p_len) begin
          push_result(KIND_DATA, b, 1'b1);
          p_state = PS_IDLE;
        end else begin
          push_result(KIND_DATA, b, 1'b0);
        end
      end
      default: begin
        p_fin     = b[7];
        p_opc     = b[3:0];
        p_msk     = 1'b0;
        p_len     = '0;
        p_key     = '0;
        p_cnt     = '0;
        p_hdr_cnt = 4'd1;
        p_state   = PS_LEN;
      end
    endcase
    // End of buffer inside a frame: error beat and back to reset state.
    if (beat.end_of_buffer && p_state != PS_IDLE) begin
      err             = '0;
      err.result_kind = KIND_TRUNC;
      err.frame_end   = 1'b1;
      frame_results_q.push_back(err);
      p_state   = PS_IDLE;
      p_hdr_cnt = '0;
      p_fin     = 1'b0;
      p_opc     = '0;
      p_msk     = 1'b0;
      p_len     = '0;
      p_key     = '0;
      p_cnt     = '0;
    end
  endfunction

  // Queues one random frame, possibly cut short, or a burst of line noise.
  // Every unit leaves the parser idle.
  function automatic void queue_frame();
    logic [7:0]  bytes [$];
    logic [63:0] plen;
    logic [6:0]  code;
    logic        msk;
    logic        huge;
    logic        chop;
    int unsigned pick;
    int unsigned n_pay;
    int unsigned total;
    int unsigned cut;
    int unsigned stop;
    wdf_in_t     beat;
    pick = $urandom_range(0, 19);
    if (pick >= 18) begin
      // Noise; the end-of-buffer mark on the last byte resets the parse.
      repeat ($urandom_range(1, 6)) bytes.push_back(8'($urandom_range(0, 255)));
      total = bytes.size();
      chop  = 1'b1;
      cut   = total - 1;
    end else begin
      msk = 1'($urandom_range(0, 1));
      bytes.push_back(8'($urandom_range(0, 255)));
      if (pick < 11) begin
        plen = ($urandom_range(0, 7) == 0) ? 64'd125 : 64'($urandom_range(0, 12));
        code = plen[6:0];
      end else if (pick < 15) begin
        code = 7'd126;
        plen = ($urandom_range(0, 15) == 0) ? 64'($urandom_range(0, 65535))
                                             : 64'($urandom_range(0, 40));
      end else begin
        code = 7'd127;
        plen = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(0, 24));
      end
      bytes.push_back({msk, code});
      if (code == 7'd126) begin
        bytes.push_back(plen[15:8]);
        bytes.push_back(plen[7:0]);
      end
      if (code == 7'd127) begin
        for (int i = 7; i >= 0; i--) bytes.push_back(plen[8*i +: 8]);
      end
      if (msk) repeat (4) bytes.push_back(8'($urandom_range(0, 255)));
      // Long frames are always cut inside the buffer.
      huge  = (plen > 64'd48);
      n_pay = huge ? $urandom_range(0, 48) : int'(plen);
      repeat (n_pay) bytes.push_back(8'($urandom_range(0, 255)));
      total = bytes.size();
      chop  = huge || ($urandom_range(0, 7) == 0);
      if (chop) begin
        cut = huge ? $urandom_range(0, total - 1) : $urandom_range(0, total - 2);
      end else begin
        // Sometimes the buffer ends exactly with the frame.
        cut = ($urandom_range(0, 3) == 0) ? total - 1 : total;
      end
    end
    stop = chop ? cut + 1 : total;
    for (int unsigned i = 0; i < stop; i++) begin
      beat.in_byte       = bytes[i];
      beat.end_of_buffer = (i == cut);
      frame_bytes_q.push_back(beat);
    end
  endfunction

  // Drives one input beat, holding it until the handshake completes.
  task automatic send_beat(wdf_in_t beat);
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    parse_byte(beat);
  endtask

  // Output side: random backpressure and the check of every result beat.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_results_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat %s", beat_str(out_data_o)));
      end else begin
        automatic wdf_out_t want = frame_results_q.pop_front();
        if (out_data_o.result_kind    !== want.result_kind    ||
            out_data_o.fin_flag       !== want.fin_flag       ||
            out_data_o.frame_opcode   !== want.frame_opcode   ||
            out_data_o.masked_flag    !== want.masked_flag    ||
            out_data_o.payload_length !== want.payload_length ||
            out_data_o.header_length  !== want.header_length  ||
            out_data_o.data_byte      !== want.data_byte      ||
            out_data_o.frame_end      !== want.frame_end) begin
          flag_mismatch($sformatf("expected %s, got %s", beat_str(want),
                                  beat_str(out_data_o)));
        end
      end
    end
    out_ready_i <= steady || ($urandom_range(0, 99) >= 10);
  end

  // Stimulus and end of run.
  initial begin
    wdf_in_t beat;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows.
    foreach (dir_tab[i]) begin
      beat.in_byte       = dir_tab[i].in_byte;
      beat.end_of_buffer = dir_tab[i].eob;
      send_beat(beat);
      if (dir_tab[i].pinned) frame_results_q[frame_results_q.size() - 1] = dir_tab[i].want;
    end

    // Random frames, with one stretch free of idling on both sides.
    while (random_sent < RANDOM_BEATS) begin
      queue_frame();
      while (frame_bytes_q.size() != 0) begin
        steady = (random_sent >= 250 && random_sent < 400);
        send_beat(frame_bytes_q.pop_front());
        random_sent++;
      end
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    // Drain, then wait for any stray beat.
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (frame_results_q.size() != 0) flag_mismatch("expected beats never arrived");

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/wdf_pkg.sv
rtl/wdf_parser.sv
rtl/wdf_queue.sv
rtl/wdf_emitter.sv
rtl/websocket_frame_deframer_top.sv
sim/websocket_frame_deframer_top_tb.sv
